// File: hdl/cdv_pkg.sv
// shared constants for the central difference velocity block
package cdv_pkg;

    localparam int DEF_POSITION_BITS = 32;
    localparam int DEF_STAMP_BITS    = 32;
    localparam int DEF_VELOCITY_BITS = 32;

    // microseconds per second as decimal digits, and the bits that 10^6 needs
    localparam int USEC_DIGITS = 6;
    localparam int SCALE_BITS  = 20;

    // result queue depth, a power of two of at least four
    localparam int FIFO_DEPTH = 4;

endpackage

// File: hdl/cdv_point_if.sv
// trajectory point channel: position, time stamp and end-of-path flag
interface cdv_point_if
    import cdv_pkg::*;
#(
    parameter int POSITION_BITS = DEF_POSITION_BITS,
    parameter int STAMP_BITS    = DEF_STAMP_BITS
);
    logic                            valid;
    logic                            ready;
    logic signed [POSITION_BITS-1:0] position;
    logic        [STAMP_BITS-1:0]    stamp_us;
    logic                            end_of_path;

    modport source (output valid, output position, output stamp_us, output end_of_path,
                    input ready);
    modport sink   (input valid, input position, input stamp_us, input end_of_path,
                    output ready);
endinterface

// File: hdl/cdv_velocity_if.sv
// velocity result channel: velocity, zero-interval flag and final-point flag
interface cdv_velocity_if
    import cdv_pkg::*;
#(
    parameter int VELOCITY_BITS = DEF_VELOCITY_BITS
);
    logic                            valid;
    logic                            ready;
    logic signed [VELOCITY_BITS-1:0] velocity;
    logic                            zero_interval;
    logic                            final_point;

    modport source (output valid, output velocity, output zero_interval, output final_point,
                    input ready);
    modport sink   (input valid, input velocity, input zero_interval, input final_point,
                    output ready);
endinterface

// File: hdl/cdv_divider.sv
// serial scale-by-10^6 and radix-2 restoring divide, one quotient bit per cycle
module cdv_divider
    import cdv_pkg::*;
#(
    parameter int A_BITS = DEF_POSITION_BITS + 1,
    parameter int D_BITS = DEF_STAMP_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [A_BITS-1:0]            i_dividend,
    input  logic [D_BITS-1:0]            i_divisor,
    output logic                         o_done,
    output logic [A_BITS+SCALE_BITS-1:0] o_quotient
);
    localparam int N_BITS = A_BITS + SCALE_BITS;
    localparam int CNT_W  = $clog2(N_BITS);

    typedef enum logic [3:0] {
        D_IDLE   = 4'b0001,
        D_SCALE  = 4'b0010,
        D_DIVIDE = 4'b0100,
        D_DONE   = 4'b1000
    } t_div_state;

    t_div_state          r_state, n_state;
    logic [N_BITS-1:0]   r_num, n_num;
    logic [D_BITS-1:0]   r_rem, n_rem;
    logic [D_BITS-1:0]   r_den, n_den;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    logic [D_BITS:0]     w_rem_sh;
    logic [D_BITS+1:0]   w_diff;
    logic                w_borrow;

    // remainder shifted left with the next dividend bit, then trial subtract
    assign w_rem_sh = {r_rem, r_num[N_BITS-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_den};
    assign w_borrow = w_diff[D_BITS+1];

    always_comb begin
        n_state = r_state;
        n_num   = r_num;
        n_rem   = r_rem;
        n_den   = r_den;
        n_cnt   = r_cnt;
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_num   = N_BITS'(i_dividend);
                    n_den   = i_divisor;
                    n_rem   = '0;
                    n_cnt   = CNT_W'(USEC_DIGITS - 1);
                    n_state = D_SCALE;
                end
            end
            D_SCALE: begin
                // times ten as two shifted copies
                n_num = (r_num << 3) + (r_num << 1);
                if (r_cnt == '0) begin
                    n_cnt   = CNT_W'(N_BITS - 1);
                    n_state = D_DIVIDE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            D_DIVIDE: begin
                n_rem = w_borrow ? w_rem_sh[D_BITS-1:0] : w_diff[D_BITS-1:0];
                n_num = {r_num[N_BITS-2:0], ~w_borrow};
                if (r_cnt == '0) begin
                    n_state = D_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            D_DONE: begin
                n_state = D_IDLE;
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done     = (r_state == D_DONE);
    assign o_quotient = r_num;

endmodule

// File: hdl/cdv_fifo.sv
// small result queue in flip-flops, one push and one pop per cycle
module cdv_fifo
    import cdv_pkg::*;
#(
    parameter int WIDTH = DEF_VELOCITY_BITS + 2,
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    output logic             o_room
);
    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    // space for the two beats one point can cause
    assign o_room  = (r_count <= (PTR_W+1)'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hdl/central_difference_velocity.sv
// central difference velocity of a streamed joint trajectory, top level
//
// Each input beat is one trajectory point (position, microsecond stamp, end-of-path flag).
// The block keeps the two previous points and, when point j+1 arrives, delivers the
// velocity of point j as (p[j+1]-p[j-1]) * 10^6 / (t[j+1]-t[j-1]), truncated toward zero
// and saturated to the velocity width. The first and last points of a path get zero,
// the last one marked with final_point; a one-point path gives one final zero beat.
// A zero time difference gives the signed limit (zero if the positions match) with
// zero_interval set. Joints are handled by streaming their paths back to back.
// Division: a point that needs one holds the block, which takes no new point, until the
// single serial divider is through, and a point that also ends the path then adds its
// final zero beat. The divider makes six times-ten steps to scale the position difference,
// then one quotient bit per cycle over the POSITION_BITS + 21 bit dividend.
// Results sit in a four-beat queue, so a new point is taken while earlier
// results still wait downstream, as long as room for two beats remains.
module central_difference_velocity
    import cdv_pkg::*;
#(
    parameter int POSITION_BITS = DEF_POSITION_BITS,
    parameter int STAMP_BITS    = DEF_STAMP_BITS,
    parameter int VELOCITY_BITS = DEF_VELOCITY_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cdv_point_if.sink             i_point,
    cdv_velocity_if.source        o_velocity
);
    localparam int A_BITS = POSITION_BITS + 1;
    localparam int Q_BITS = A_BITS + SCALE_BITS;
    localparam int QW     = (Q_BITS > VELOCITY_BITS) ? Q_BITS : VELOCITY_BITS;
    localparam int F_BITS = VELOCITY_BITS + 2;

    localparam logic [VELOCITY_BITS-1:0] VEL_MAX = {1'b0, {(VELOCITY_BITS-1){1'b1}}};
    localparam logic [VELOCITY_BITS-1:0] VEL_MIN = {1'b1, {(VELOCITY_BITS-1){1'b0}}};

    // controller states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WAIT = 4'b0010,
        S_EMIT = 4'b0100,
        S_LAST = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic [POSITION_BITS-1:0] r_older_pos, r_newer_pos;
    logic [STAMP_BITS-1:0]    r_older_stamp, r_newer_stamp;
    logic [1:0]               r_points_seen;
    logic                     r_last, n_last;
    logic                     r_neg, n_neg;
    logic [VELOCITY_BITS-1:0] r_res_vel, n_res_vel;
    logic                     r_res_zi, n_res_zi;

    logic                     w_accept;
    logic [POSITION_BITS:0]   w_dp;
    logic [STAMP_BITS:0]      w_dt;
    logic                     w_dp_neg, w_dp_zero, w_dt_neg, w_dt_zero;
    logic [A_BITS-1:0]        w_mag_a;
    logic [STAMP_BITS:0]      w_mag_dt;
    logic [VELOCITY_BITS-1:0] w_sign_vel;

    logic                     w_div_start, w_div_done;
    logic [Q_BITS-1:0]        w_quot;
    logic [QW-1:0]            w_q_ext;
    logic                     w_over;
    logic [VELOCITY_BITS-1:0] w_q_low, w_div_vel;

    logic                     w_push;
    logic [F_BITS-1:0]        w_push_data;
    logic                     w_fifo_valid, w_fifo_room;
    logic [F_BITS-1:0]        w_fifo_data;

    // input side takes a point only between points and with room for two beats
    assign i_point.ready = (r_state == S_IDLE) && w_fifo_room;
    assign w_accept      = i_point.valid && i_point.ready;

    // exact differences against the point two back
    assign w_dp = {i_point.position[POSITION_BITS-1], i_point.position}
                - {r_older_pos[POSITION_BITS-1], r_older_pos};
    assign w_dt = {1'b0, i_point.stamp_us} - {1'b0, r_older_stamp};

    assign w_dp_neg  = w_dp[POSITION_BITS];
    assign w_dp_zero = (w_dp == '0);
    assign w_dt_neg  = w_dt[STAMP_BITS];
    assign w_dt_zero = (w_dt == '0);

    // magnitudes for the unsigned divider
    assign w_mag_a  = w_dp_neg ? (~w_dp + {{POSITION_BITS{1'b0}}, 1'b1}) : w_dp;
    assign w_mag_dt = w_dt_neg ? (~w_dt + {{STAMP_BITS{1'b0}}, 1'b1}) : w_dt;

    // zero interval: the limit in the direction of motion, or zero for no motion
    assign w_sign_vel = w_dp_zero ? '0 : (w_dp_neg ? VEL_MIN : VEL_MAX);

    assign w_div_start = w_accept && (r_points_seen == 2'd2) && !w_dt_zero;

    cdv_divider #(
        .A_BITS (A_BITS),
        .D_BITS (STAMP_BITS)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag_a),
        .i_divisor  (w_mag_dt[STAMP_BITS-1:0]),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // saturate the unsigned quotient, then apply the sign
    assign w_q_ext   = QW'(w_quot);
    assign w_over    = |(w_q_ext >> (VELOCITY_BITS - 1));
    assign w_q_low   = w_q_ext[VELOCITY_BITS-1:0];
    assign w_div_vel = r_neg ? (w_over ? VEL_MIN : (~w_q_low + 1'b1))
                             : (w_over ? VEL_MAX : w_q_low);

    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_neg       = r_neg;
        n_res_vel   = r_res_vel;
        n_res_zi    = r_res_zi;
        w_push      = 1'b0;
        w_push_data = {r_res_vel, r_res_zi, 1'b0};
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_last = i_point.end_of_path;
                    n_neg  = w_dp_neg ^ w_dt_neg;
                    if (r_points_seen == 2'd0) begin
                        // first point of a path: nothing yet unless it is also the last
                        n_state = i_point.end_of_path ? S_LAST : S_IDLE;
                    end else if (r_points_seen == 2'd1) begin
                        // second point releases the first point's zero
                        n_res_vel = '0;
                        n_res_zi  = 1'b0;
                        n_state   = S_EMIT;
                    end else if (w_dt_zero) begin
                        n_res_vel = w_sign_vel;
                        n_res_zi  = 1'b1;
                        n_state   = S_EMIT;
                    end else begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (w_div_done) begin
                    n_res_vel = w_div_vel;
                    n_res_zi  = 1'b0;
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                w_push  = 1'b1;
                n_state = r_last ? S_LAST : S_IDLE;
            end
            S_LAST: begin
                // last point of the path: zero with the final mark
                w_push      = 1'b1;
                w_push_data = {{VELOCITY_BITS{1'b0}}, 1'b0, 1'b1};
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_points_seen <= 2'd0;
            r_older_pos   <= '0;
            r_newer_pos   <= '0;
            r_older_stamp <= '0;
            r_newer_stamp <= '0;
            r_last        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            if (w_accept) begin
                if (i_point.end_of_path) begin
                    // next beat opens a new path
                    r_points_seen <= 2'd0;
                end else begin
                    r_older_pos   <= r_newer_pos;
                    r_older_stamp <= r_newer_stamp;
                    r_newer_pos   <= i_point.position;
                    r_newer_stamp <= i_point.stamp_us;
                    if (r_points_seen != 2'd2) begin
                        r_points_seen <= r_points_seen + 1'b1;
                    end
                end
            end
        end
        r_neg     <= n_neg;
        r_res_vel <= n_res_vel;
        r_res_zi  <= n_res_zi;
    end

    cdv_fifo #(
        .WIDTH (F_BITS),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (o_velocity.ready),
        .o_valid (w_fifo_valid),
        .o_data  (w_fifo_data),
        .o_room  (w_fifo_room)
    );

    assign o_velocity.valid         = w_fifo_valid;
    assign o_velocity.velocity      = w_fifo_data[F_BITS-1:2];
    assign o_velocity.zero_interval = w_fifo_data[1];
    assign o_velocity.final_point   = w_fifo_data[0];

    // divider finishes only while the controller waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_WAIT)
        else $error("divider done outside wait state");

    // an interior point with a nonzero interval always goes to the divider
    a_div_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> r_state == S_WAIT)
        else $error("division started but controller not waiting");

    // end of path is followed by its final zero beat
    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && r_last |=> r_state == S_LAST)
        else $error("final beat missing after end of path");

endmodule
